@@ rtl/core/pbc_pkg.sv @@
// pbc_pkg: widths, codes and shared types for the plane box classifier
// no dependencies; imported by every module of the block

package pbc_pkg;

  // coordinate width of the box corners (signed Q16.16, sign extended)
  localparam int COORD_WIDTH = 32;

  // plane registers and fixed-point layout
  localparam int NORM_W     = 32;
  localparam int TOL_W      = 16;
  localparam int FRAC_W     = 16;

  // exact product, partial sum and full distance widths (Q32.32, Q33.32, Q34.32)
  localparam int PROD_W     = COORD_WIDTH + NORM_W;
  localparam int PSUM_W     = PROD_W + 1;
  localparam int DIST_W     = PROD_W + 2;

  // eight box corners, index bit 2 picks x max, bit 1 y max, bit 0 z max
  localparam int CORNER_W   = 3;
  localparam int N_CORNERS  = 1 << CORNER_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = CFG_IDX_W'(4);

  // side codes
  localparam logic signed [1:0] SIDE_BEHIND = 2'sb11;
  localparam logic signed [1:0] SIDE_ON     = 2'sb00;
  localparam logic signed [1:0] SIDE_FRONT  = 2'sb01;

  // plane configuration
  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic signed [NORM_W-1:0] plane_offset;
    logic        [TOL_W-1:0]  tolerance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    normal_x:     NORM_W'(0),
    normal_y:     NORM_W'(0),
    normal_z:     NORM_W'(65536),
    plane_offset: NORM_W'(0),
    tolerance:    TOL_W'(7)
  };

  // one box as its two corners
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] min_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;
  } box_t;

  // exact coordinate-by-normal products for both corners on each axis
  typedef struct packed {
    logic signed [PROD_W-1:0] lo_x;
    logic signed [PROD_W-1:0] hi_x;
    logic signed [PROD_W-1:0] lo_y;
    logic signed [PROD_W-1:0] hi_y;
    logic signed [PROD_W-1:0] lo_z;
    logic signed [PROD_W-1:0] hi_z;
  } prod_t;

endpackage

@@ rtl/core/pbc_mult_stage.sv @@
// pbc_mult_stage: input register and the six exact axis products
// depends on pbc_pkg

module pbc_mult_stage import pbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  box_t  box,
  input  cfg_t  cfg,
  output logic  prod_valid,
  output prod_t prod
);

  logic box_valid;
  box_t box_q;

  // stage 0: capture the box
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else begin
      box_valid <= in_valid;
    end
    if (in_valid) begin
      box_q <= box;
    end
  end

  // stage 1: one multiplier per coordinate, products kept exact
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= box_valid;
    end
    if (box_valid) begin
      prod.lo_x <= PROD_W'(box_q.min_x) * PROD_W'(cfg.normal_x);
      prod.hi_x <= PROD_W'(box_q.max_x) * PROD_W'(cfg.normal_x);
      prod.lo_y <= PROD_W'(box_q.min_y) * PROD_W'(cfg.normal_y);
      prod.hi_y <= PROD_W'(box_q.max_y) * PROD_W'(cfg.normal_y);
      prod.lo_z <= PROD_W'(box_q.min_z) * PROD_W'(cfg.normal_z);
      prod.hi_z <= PROD_W'(box_q.max_z) * PROD_W'(cfg.normal_z);
    end
  end

endmodule

@@ rtl/core/pbc_sum_stage.sv @@
// pbc_sum_stage: partial sums and the eight corner distances at Q34.32
// depends on pbc_pkg

module pbc_sum_stage import pbc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     prod_valid,
  input  prod_t                    prod,
  input  cfg_t                     cfg,
  output logic                     dist_valid,
  output logic signed [DIST_W-1:0] corner_dist [N_CORNERS]
);

  logic                     psum_valid;
  logic signed [PSUM_W-1:0] xy_sum [N_CORNERS/2];
  logic signed [PSUM_W-1:0] zo_sum [2];
  logic signed [PSUM_W-1:0] off_term;

  // offset scaled by 2^16 to line up with the products
  assign off_term = PSUM_W'(signed'({cfg.plane_offset, FRAC_W'(0)}));

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      psum_valid <= 1'b0;
    end else begin
      psum_valid <= prod_valid;
    end
  end

  // stage 2: x plus y for the four xy corner pairs
  for (genvar k = 0; k < N_CORNERS / 2; k++) begin : g_xy
    localparam bit X_HI = ((k >> 1) & 1) == 1;
    localparam bit Y_HI = (k & 1) == 1;
    always_ff @(posedge clk) begin
      if (prod_valid) begin
        xy_sum[k] <= PSUM_W'(X_HI ? prod.hi_x : prod.lo_x)
                   + PSUM_W'(Y_HI ? prod.hi_y : prod.lo_y);
      end
    end
  end

  // stage 2: z less the scaled offset for both z choices
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      zo_sum[0] <= PSUM_W'(prod.lo_z) - off_term;
      zo_sum[1] <= PSUM_W'(prod.hi_z) - off_term;
    end
  end

  // stage 3 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else begin
      dist_valid <= psum_valid;
    end
  end

  // stage 3: full distance of each corner
  for (genvar i = 0; i < N_CORNERS; i++) begin : g_dist
    localparam int XY_IDX = i >> 1;
    localparam int Z_IDX  = i & 1;
    always_ff @(posedge clk) begin
      if (psum_valid) begin
        corner_dist[i] <= DIST_W'(xy_sum[XY_IDX]) + DIST_W'(zo_sum[Z_IDX]);
      end
    end
  end

endmodule

@@ rtl/core/pbc_classify_stage.sv @@
// pbc_classify_stage: tolerance band compares, outside test and side code
// depends on pbc_pkg

module pbc_classify_stage import pbc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     dist_valid,
  input  logic signed [DIST_W-1:0] corner_dist [N_CORNERS],
  input  cfg_t                     cfg,
  output logic                     done,
  output logic signed [1:0]        side,
  output logic                     outside
);

  logic signed [DIST_W-1:0] tol_pos;
  logic signed [DIST_W-1:0] tol_neg;
  logic [CORNER_W-1:0]      corner_sel;
  logic                     flag_valid;
  logic [N_CORNERS-1:0]     behind;
  logic [N_CORNERS-1:0]     front;
  logic                     outside_q;

  // band edges at Q34.32
  assign tol_pos = DIST_W'(signed'({1'b0, cfg.tolerance, FRAC_W'(0)}));
  assign tol_neg = -tol_pos;

  // per axis a negative normal picks the max coordinate
  assign corner_sel = {cfg.normal_x[NORM_W-1], cfg.normal_y[NORM_W-1],
                       cfg.normal_z[NORM_W-1]};

  // stage 4: compare every corner against the band
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_valid <= 1'b0;
    end else begin
      flag_valid <= dist_valid;
    end
    if (dist_valid) begin
      for (int i = 0; i < N_CORNERS; i++) begin
        behind[i] <= corner_dist[i] < tol_neg;
        front[i]  <= corner_dist[i] > tol_pos;
      end
      outside_q <= !corner_dist[corner_sel][DIST_W-1];
    end
  end

  // stage 5: result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= flag_valid;
    end
    if (flag_valid) begin
      outside <= outside_q;
      priority if ((|behind) && (|front)) begin
        side <= SIDE_ON;
      end else if (|behind) begin
        side <= SIDE_BEHIND;
      end else if (|front) begin
        side <= SIDE_FRONT;
      end else begin
        side <= SIDE_ON;
      end
    end
  end

endmodule

@@ rtl/core/plane_box_classifier_unit.sv @@
// plane_box_classifier_unit: classifies one axis-aligned box per cycle against a plane
// done follows start via the box, product, psum, dist, flag and result registers
// throughput: one box every cycle; busy stays low, the six-stage pipeline never stalls
// reset: synchronous, clears the pipeline valid bits and loads the plane registers
// with their defaults (normal 0,0,1; offset 0; tolerance 7); needs pbc_pkg and stages

module plane_box_classifier_unit import pbc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] min_x,
  input  logic signed [COORD_WIDTH-1:0] min_y,
  input  logic signed [COORD_WIDTH-1:0] min_z,
  input  logic signed [COORD_WIDTH-1:0] max_x,
  input  logic signed [COORD_WIDTH-1:0] max_y,
  input  logic signed [COORD_WIDTH-1:0] max_z,
  output logic                          done,
  output logic signed [1:0]             side,
  output logic                          outside,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cfg_t                     cfg;
  box_t                     box;
  logic                     in_valid;
  logic                     prod_valid;
  prod_t                    prod;
  logic                     dist_valid;
  logic signed [DIST_W-1:0] corner_dist [N_CORNERS];

  // fully pipelined, every start is taken
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_valid  = start && !busy;

  assign box = '{min_x: min_x, min_y: min_y, min_z: min_z,
                 max_x: max_x, max_y: max_y, max_z: max_z};

  // plane registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NORMAL_X:     cfg.normal_x     <= cfg_data[NORM_W-1:0];
        CFG_NORMAL_Y:     cfg.normal_y     <= cfg_data[NORM_W-1:0];
        CFG_NORMAL_Z:     cfg.normal_z     <= cfg_data[NORM_W-1:0];
        CFG_PLANE_OFFSET: cfg.plane_offset <= cfg_data[NORM_W-1:0];
        CFG_TOLERANCE:    cfg.tolerance    <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // products
  pbc_mult_stage u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .box        (box),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  // corner distances
  pbc_sum_stage u_sum (
    .clk         (clk),
    .rst         (rst),
    .prod_valid  (prod_valid),
    .prod        (prod),
    .cfg         (cfg),
    .dist_valid  (dist_valid),
    .corner_dist (corner_dist)
  );

  // classification and result
  pbc_classify_stage u_classify (
    .clk         (clk),
    .rst         (rst),
    .dist_valid  (dist_valid),
    .corner_dist (corner_dist),
    .cfg         (cfg),
    .done        (done),
    .side        (side),
    .outside     (outside)
  );

endmodule

@@ rtl/core/pbc_checker.sv @@
// pbc_checker: port-level assertions for plane_box_classifier_unit
// depends on pbc_pkg; attached to the top level by the bind below

module pbc_checker import pbc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic signed [1:0] side,
  input logic              outside
);

  // every transfer in gives a result
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted box gave no result");

  // no result without an earlier transfer in
  a_done_has_source: assert property (@(posedge clk)
    done |-> $past(start && !busy && !rst, 6))
    else $error("result without an accepted box");

  // the pipeline never holds off a box
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  // the unused side code never shows
  a_side_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (side == SIDE_BEHIND || side == SIDE_ON || side == SIDE_FRONT))
    else $error("illegal side code");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result straight after reset");

endmodule

bind plane_box_classifier_unit pbc_checker u_pbc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .side    (side),
  .outside (outside)
);
